### rtl/b2da_pkg.sv
// shared constants, types and helpers for the binary to decimal ascii converter
// no dependencies

package b2da_pkg;

  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned IN_TDATA_W     = 64;
  localparam int unsigned OUT_TDATA_W    = 8;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned ASCII_W        = 6;

  // upper two bits of the 6-bit code for '0' .. '9'
  localparam logic [ASCII_W-DIGIT_W-1:0] ASCII_DIGIT_HI = 2'b11;

  // decimal digits of 2^bits - 1, using log10(2) ~ 0.30103
  function automatic int unsigned num_digits(input int unsigned bits);
    num_digits = (bits * 30103) / 100000 + 1;
  endfunction

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_SKIP,
    EM_SEND
  } emit_state_e;

endpackage

### rtl/binary_to_decimal_ascii.sv
// top level of the binary to decimal ascii converter
// depends on b2da_pkg, b2da_dabble and b2da_emit
//
// usage:
//   slave side: one request carries an unsigned value in s_axis_tdata; only the
//   low VALUE_BITS bits count. master side: one request per decimal digit, as
//   ascii '0'..'9' in m_axis_tdata[5:0], most significant digit first, with no
//   leading zeros; zero gives a single '0'. m_axis_tlast marks the last digit.
// flow:
//   the shift-and-add-3 unit takes one input bit per cycle, then hands the bcd
//   word to the serializer once that one is idle. the serializer drops one leading
//   zero per cycle, moves from its skip state to its send state, then sends one
//   digit per cycle while m_axis_tready is high. the next value converts while
//   digits go out.
// reset:
//   rst_ni clears both control paths; no request is pending afterwards.
// stall:
//   a low m_axis_tready holds the current digit; a finished conversion waits
//   in the converter and s_axis_tready stays low until it is handed over.

module binary_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = b2da_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave side
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [b2da_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [63:0] value
  // master side
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [b2da_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [5:0] ascii_digit, [7:6] zero
  output logic                                m_axis_tlast    // last_digit
);
  import b2da_pkg::*;

  // digits needed for the largest value of VALUE_BITS bits
  localparam int unsigned NUM_DIGITS = num_digits(VALUE_BITS);

  logic                    conv_ready;
  logic                    conv_done;
  logic                    emit_ready;
  logic                    hand_over;
  logic [4*NUM_DIGITS-1:0] conv_bcd;
  logic [ASCII_W-1:0]      ascii_digit;

  // converter result moves to the serializer once that one is idle
  assign hand_over = conv_done && emit_ready;

  b2da_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .NUM_DIGITS (NUM_DIGITS)
  ) u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s_axis_tvalid),
    .value_i (s_axis_tdata[VALUE_BITS-1:0]),
    .ready_o (conv_ready),
    .done_o  (conv_done),
    .take_i  (emit_ready),
    .bcd_o   (conv_bcd)
  );

  b2da_emit #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (hand_over),
    .bcd_i    (conv_bcd),
    .ready_o  (emit_ready),
    .valid_o  (m_axis_tvalid),
    .accept_i (m_axis_tready),
    .ascii_o  (ascii_digit),
    .last_o   (m_axis_tlast)
  );

  assign s_axis_tready = conv_ready;
  // pad the 6-bit code up to a whole byte
  assign m_axis_tdata  = {{(OUT_TDATA_W-ASCII_W){1'b0}}, ascii_digit};

endmodule

### rtl/b2da_dabble.sv
// bit-serial shift-and-add-3 conversion of one binary value into packed bcd
// depends on b2da_pkg

module b2da_dabble #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned NUM_DIGITS = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic [VALUE_BITS-1:0]   value_i,
  output logic                    ready_o,
  output logic                    done_o,
  input  logic                    take_i,
  output logic [4*NUM_DIGITS-1:0] bcd_o
);
  import b2da_pkg::*;

  localparam int unsigned CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int unsigned BCD_W = DIGIT_W * NUM_DIGITS;

  logic [VALUE_BITS-1:0] shift_q, shift_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d, bcd_adj;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    logic [DIGIT_W-1:0] dig;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dig = bcd_q[i*DIGIT_W +: DIGIT_W];
      bcd_adj[i*DIGIT_W +: DIGIT_W] = (dig >= DIGIT_W'(5)) ? dig + DIGIT_W'(3) : dig;
    end
  end

  always_comb begin
    shift_d = shift_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = done_q;
    if (busy_q) begin
      bcd_d   = {bcd_adj[BCD_W-2:0], shift_q[VALUE_BITS-1]};
      shift_d = {shift_q[VALUE_BITS-2:0], 1'b0};
      cnt_d   = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (done_q) begin
      if (take_i) begin
        done_d = 1'b0;
      end
    end else if (load_i) begin
      shift_d = value_i;
      bcd_d   = '0;
      cnt_d   = CNT_W'(VALUE_BITS - 1);
      busy_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    bcd_q   <= bcd_d;
  end

  assign ready_o = !busy_q && !done_q;
  assign done_o  = done_q;
  assign bcd_o   = bcd_q;

endmodule

### rtl/b2da_emit.sv
// digit serializer: drops leading zeros, then sends one ascii digit per request
// depends on b2da_pkg

module b2da_emit #(
  parameter int unsigned NUM_DIGITS = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic [4*NUM_DIGITS-1:0] bcd_i,
  output logic                    ready_o,
  output logic                    valid_o,
  input  logic                    accept_i,
  output logic [b2da_pkg::ASCII_W-1:0] ascii_o,
  output logic                    last_o
);
  import b2da_pkg::*;

  localparam int unsigned BCD_W = DIGIT_W * NUM_DIGITS;
  localparam int unsigned REM_W = $clog2(NUM_DIGITS + 1);

  emit_state_e        state_q, state_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [DIGIT_W-1:0] top_dig;
  logic               is_last;

  assign top_dig = bcd_q[BCD_W-1 -: DIGIT_W];
  assign is_last = (rem_q == REM_W'(1));

  always_comb begin
    state_d = state_q;
    bcd_d   = bcd_q;
    rem_d   = rem_q;
    ready_o = 1'b0;
    valid_o = 1'b0;
    case (state_q)
      EM_IDLE: begin
        ready_o = 1'b1;
        if (load_i) begin
          bcd_d   = bcd_i;
          rem_d   = REM_W'(NUM_DIGITS);
          state_d = EM_SKIP;
        end
      end
      EM_SKIP: begin
        if (top_dig == '0 && !is_last) begin
          bcd_d = {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          rem_d = rem_q - REM_W'(1);
        end else begin
          state_d = EM_SEND;
        end
      end
      EM_SEND: begin
        valid_o = 1'b1;
        if (accept_i) begin
          if (is_last) begin
            state_d = EM_IDLE;
          end else begin
            bcd_d = {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            rem_d = rem_q - REM_W'(1);
          end
        end
      end
      default: begin
        state_d = EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EM_IDLE;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
  end

  assign ascii_o = {ASCII_DIGIT_HI, top_dig};
  assign last_o  = is_last;

endmodule

### bench/binary_to_decimal_ascii_test.sv
// self-checking bench for binary_to_decimal_ascii: streams values in, checks every digit out
// depends on b2da_pkg and the binary_to_decimal_ascii rtl
`timescale 1ns / 100ps

module binary_to_decimal_ascii_test;
  import b2da_pkg::*;

  localparam int unsigned VALUE_BITS    = VALUE_BITS_DEF;
  localparam int unsigned WATCHDOG_MAX  = 2000;  // cycles with no request on either side
  localparam int unsigned DRAIN_CYCLES  = 150;   // quiet time after the last digit

  // one expected digit of the decimal text
  typedef struct packed {
    logic [ASCII_W-1:0] ascii;
    logic               last;
  } digit_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [63:0] value
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [5:0] ascii_digit, [7:6] zero
  logic                   m_axis_tlast;   // last_digit

  digit_t      pending_digits[$];  // digits still owed by the converter, oldest first
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idling = 1'b0;   // when set neither side inserts bubbles

  binary_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // decimal text of one value, most significant digit first, no leading zeros
  function automatic void queue_decimal_text(input logic [IN_TDATA_W-1:0] value);
    logic [IN_TDATA_W-1:0] rest;
    logic [DIGIT_W-1:0]    lsd_first[$];
    digit_t                d;
    // only the low VALUE_BITS bits take part
    rest = (VALUE_BITS >= IN_TDATA_W) ? value : (value & ((64'd1 << VALUE_BITS) - 64'd1));
    // zero still yields one digit
    do begin
      lsd_first.push_back(DIGIT_W'(rest % 64'd10));
      rest = rest / 64'd10;
    end while (rest != 0);
    for (int k = lsd_first.size() - 1; k >= 0; k--) begin
      d.ascii = {ASCII_DIGIT_HI, lsd_first[k]};
      d.last  = (k == 0);
      pending_digits.push_back(d);
    end
  endfunction

  // present one value and hold it until the converter takes it; valid stays up
  // into the next request unless a bubble is drawn afterwards
  task automatic send_value(input logic [IN_TDATA_W-1:0] value);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    queue_decimal_text(value);
    gap = 0;
    while (!no_idling && $urandom_range(99) < 8) begin
      gap++;
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drop valid for one cycle between tests
  task automatic end_stream();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [IN_TDATA_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // edges of the range, digit-count boundaries, the narrower overload maxima,
  // all ones and all zeros so every input bit sees both levels
  task automatic test_directed();
    send_value(64'd0);
    send_value(64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value(64'd99);
    send_value(64'd100);
    send_value(64'd255);
    send_value(64'd256);
    send_value(64'd65535);
    send_value(64'd1000000);
    send_value(64'h0000_0000_FFFF_FFFF);
    send_value(64'h0000_0001_0000_0000);
    send_value(64'd999999999999);
    send_value(64'h5555_5555_5555_5555);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
    send_value(64'h7FFF_FFFF_FFFF_FFFF);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'd9999999999999999999);
    // 10^19: first value with twenty digits
    send_value(64'd10000000000000000000);
    send_value(64'd10000000000000000001);
    // all ones: twenty digits, the longest run
    send_value(64'hFFFF_FFFF_FFFF_FFFF);
    send_value(64'd0);
    end_stream();
  endtask

  // full-width values, mostly nineteen or twenty digits
  task automatic test_random_wide(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      send_value(random_word());
    end
    end_stream();
  endtask

  // random magnitude so every run length from one digit up shows up
  task automatic test_random_lengths(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      send_value(random_word() >> $urandom_range(IN_TDATA_W - 1));
    end
    end_stream();
  endtask

  // no bubbles on either side: conversion and digit output fully overlap
  task automatic test_back_to_back(input int unsigned count);
    no_idling = 1'b1;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(3) == 0) begin
        send_value(random_word() >> $urandom_range(IN_TDATA_W - 1));
      end else begin
        send_value(random_word());
      end
    end
    end_stream();
    no_idling = 1'b0;
  endtask

  // receiver: drop ready now and then unless a no-idle stretch is running
  always @(posedge clk_i) begin
    m_axis_tready <= no_idling || ($urandom_range(99) >= 8);
  end

  // every digit request is matched against the oldest expected digit
  always @(posedge clk_i) begin
    digit_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_digits.size() == 0) begin
        error_count++;
        $display("%0t: unexpected digit tdata=%h tlast=%b", $time, m_axis_tdata,
                 m_axis_tlast);
      end else begin
        want = pending_digits.pop_front();
        if (m_axis_tdata[ASCII_W-1:0] !== want.ascii) begin
          error_count++;
          $display("%0t: ascii_digit expected %0d got %0d", $time, want.ascii,
                   m_axis_tdata[ASCII_W-1:0]);
        end
        if (m_axis_tdata[OUT_TDATA_W-1:ASCII_W] !== '0) begin
          error_count++;
          $display("%0t: tdata pad bits expected 0 got %b", $time,
                   m_axis_tdata[OUT_TDATA_W-1:ASCII_W]);
        end
        if (m_axis_tlast !== want.last) begin
          error_count++;
          $display("%0t: last_digit expected %b got %b", $time, want.last, m_axis_tlast);
        end
      end
    end
  end

  // watchdog: a stretch this long with no request anywhere means a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_wide(150);
    test_random_lengths(200);
    test_back_to_back(100);

    // let the last digits drain, then make sure nothing extra comes out
    while (pending_digits.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
